// ----- sv/ttw_pkg.sv -----
// ----------------------------------------------------------------------------
// ttw_pkg: shared types and constants for the tap tempo to wiper block
// Field widths, register codes, reset values, controller states and the
// fixed tempo table.
// ----------------------------------------------------------------------------
`default_nettype none

package ttw_pkg;

    localparam int TEMPO_W     = 11;
    localparam int ELAPSED_W   = 16;
    localparam int SCALE_W     = 17;
    localparam int WIPER_W     = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 24;
    localparam int TAPS_W      = 2;
    localparam int PROD_W      = ELAPSED_W + SCALE_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int RAW_W       = 17;
    localparam int FRAC_W      = 16;

    localparam int ROM_DEPTH   = 255;
    localparam int ROM_IDX_W   = 8;

    localparam int TABLE_SIZE_DEF = 255;
    localparam int MIN_TEMPO_DEF  = 41;

    localparam logic [TEMPO_W-1:0]   DELAY_MAX_RST   = TEMPO_W'(1184);
    localparam logic [SCALE_W-1:0]   TEMPO_SCALE_RST = SCALE_W'(65536);
    localparam logic [ELAPSED_W-1:0] TIMEOUT_RST     = ELAPSED_W'(1984);

    localparam logic [TAPS_W-1:0] TAPS_NONE = 2'd0;
    localparam logic [TAPS_W-1:0] TAPS_ONE  = 2'd1;
    localparam logic [TAPS_W-1:0] TAPS_TWO  = 2'd2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DELAY_MAX   = 2'd0,
        CFG_TEMPO_SCALE = 2'd1,
        CFG_TIMEOUT     = 2'd2
    } cfg_index_t;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_TAP  = 1'b1
    } opcode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MULT,
        ST_AVG,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_NEAR,
        ST_NEAR_LO,
        ST_NEAR_HI,
        ST_DONE
    } state_t;

    localparam logic [TEMPO_W-1:0] TEMPO_ROM [ROM_DEPTH] = '{
        11'd41,  11'd42,  11'd44,  11'd47,  11'd52,  11'd58,  11'd63,  11'd68,
        11'd73,  11'd77,  11'd82,  11'd86,  11'd90,  11'd95,  11'd99,  11'd104,
        11'd108, 11'd112, 11'd117, 11'd121, 11'd126, 11'd130, 11'd135, 11'd140,
        11'd145, 11'd149, 11'd154, 11'd159, 11'd164, 11'd168, 11'd173, 11'd177,
        11'd182, 11'd186, 11'd191, 11'd195, 11'd200, 11'd204, 11'd209, 11'd213,
        11'd217, 11'd221, 11'd225, 11'd230, 11'd234, 11'd238, 11'd243, 11'd247,
        11'd252, 11'd256, 11'd260, 11'd265, 11'd269, 11'd274, 11'd278, 11'd282,
        11'd287, 11'd292, 11'd296, 11'd301, 11'd305, 11'd310, 11'd315, 11'd319,
        11'd323, 11'd328, 11'd332, 11'd337, 11'd341, 11'd345, 11'd350, 11'd354,
        11'd359, 11'd363, 11'd367, 11'd372, 11'd376, 11'd380, 11'd384, 11'd388,
        11'd393, 11'd397, 11'd402, 11'd406, 11'd410, 11'd415, 11'd419, 11'd423,
        11'd427, 11'd431, 11'd436, 11'd440, 11'd444, 11'd449, 11'd453, 11'd458,
        11'd462, 11'd466, 11'd470, 11'd475, 11'd479, 11'd483, 11'd488, 11'd492,
        11'd496, 11'd501, 11'd505, 11'd510, 11'd514, 11'd518, 11'd523, 11'd527,
        11'd531, 11'd535, 11'd540, 11'd544, 11'd548, 11'd553, 11'd557, 11'd561,
        11'd566, 11'd570, 11'd574, 11'd579, 11'd583, 11'd587, 11'd591, 11'd595,
        11'd600, 11'd604, 11'd608, 11'd613, 11'd617, 11'd621, 11'd626, 11'd630,
        11'd634, 11'd638, 11'd642, 11'd646, 11'd651, 11'd655, 11'd659, 11'd663,
        11'd668, 11'd672, 11'd676, 11'd681, 11'd685, 11'd688, 11'd693, 11'd697,
        11'd701, 11'd706, 11'd710, 11'd718, 11'd723, 11'd727, 11'd731, 11'd735,
        11'd740, 11'd744, 11'd748, 11'd752, 11'd756, 11'd761, 11'd765, 11'd770,
        11'd773, 11'd778, 11'd782, 11'd786, 11'd791, 11'd795, 11'd799, 11'd803,
        11'd807, 11'd812, 11'd816, 11'd820, 11'd824, 11'd829, 11'd833, 11'd837,
        11'd841, 11'd846, 11'd850, 11'd854, 11'd858, 11'd862, 11'd866, 11'd871,
        11'd875, 11'd879, 11'd883, 11'd888, 11'd892, 11'd896, 11'd900, 11'd905,
        11'd909, 11'd913, 11'd917, 11'd921, 11'd925, 11'd929, 11'd933, 11'd938,
        11'd942, 11'd946, 11'd951, 11'd955, 11'd959, 11'd963, 11'd967, 11'd971,
        11'd976, 11'd980, 11'd984, 11'd988, 11'd992, 11'd996, 11'd1000, 11'd1005,
        11'd1009, 11'd1013, 11'd1018, 11'd1022, 11'd1027, 11'd1028, 11'd1033,
        11'd1038, 11'd1042, 11'd1046, 11'd1051, 11'd1055, 11'd1059, 11'd1063,
        11'd1068, 11'd1071, 11'd1076, 11'd1080, 11'd1084, 11'd1088, 11'd1093,
        11'd1097, 11'd1101, 11'd1105, 11'd1109, 11'd1113, 11'd1118, 11'd1122,
        11'd1126, 11'd1130, 11'd1134
    };

endpackage

`default_nettype wire

// ----- sv/tap_tempo_to_wiper_top.sv -----
// A tick or a first tap is taken while idle and gives no word.
// A timed tap gives its word after the states MULT, AVG, SRCH_RD/SRCH_CMP (binary search
// of the tempo table), NEAR, NEAR_LO and NEAR_HI (skipped at a table end), then DONE.
// No new tick or tap is taken during a lookup; ticks one per cycle while idle.
// Reset: rst_n asynchronous; taps, elapsed count and tempo clear, registers
// return to delay_max 1184, tempo_scale 65536, timeout_ms 1984.
// ----------------------------------------------------------------------------
// tap_tempo_to_wiper_top: tap tempo timer with nearest-entry table lookup
// Times taps from millisecond ticks, averages and clamps the tempo and
// searches the tempo table for the nearest wiper setting.
// ----------------------------------------------------------------------------
`default_nettype none

module tap_tempo_to_wiper_top #(
    parameter int TABLE_SIZE = ttw_pkg::TABLE_SIZE_DEF,
    parameter int MIN_TEMPO  = ttw_pkg::MIN_TEMPO_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [ttw_pkg::IN_DATA_W-1:0]    s_tdata,  // [0] half_ms_passed
    input  wire logic [0:0]                       s_tuser,  // [0] opcode
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [ttw_pkg::OUT_DATA_W-1:0]        m_tdata,  // [7:0] wiper, [18:8] tempo_ms
    input  wire logic                             cfg_wr_en,
    input  wire logic [ttw_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [ttw_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    import ttw_pkg::*;

    localparam int ADDR_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int POS_W  = $clog2(TABLE_SIZE + 1);
    localparam logic [POS_W-1:0] N_POS     = POS_W'(TABLE_SIZE);
    localparam logic [POS_W-1:0] STEP_INIT = POS_W'(1) << (POS_W - 1);

    state_t state_reg, state_next;

    logic [TEMPO_W-1:0]   delay_max_reg;
    logic [SCALE_W-1:0]   tempo_scale_reg;
    logic [ELAPSED_W-1:0] timeout_reg;

    logic [TAPS_W-1:0]    tap_count_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [TEMPO_W-1:0]   current_tempo_reg;

    logic [ELAPSED_W-1:0] mul_a_reg;
    logic                 second_tap_reg;
    logic [PROD_W-1:0]    product_reg;
    logic [TEMPO_W-1:0]   tempo_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     step_reg;
    logic [TEMPO_W-1:0]   lo_val_reg;
    logic [WIPER_W-1:0]   wiper_pend_reg;
    logic [TEMPO_W-1:0]   rom_data_reg;

    logic                 m_tvalid_reg;
    logic [WIPER_W-1:0]   m_wiper_reg;
    logic [TEMPO_W-1:0]   m_tempo_reg;

    logic                 in_fire;
    logic                 is_tap;
    logic                 half_ms;
    logic                 out_free;
    logic [ADDR_W-1:0]    rom_addr;
    logic [POS_W-1:0]     probe;
    logic                 probe_ok;
    logic [ELAPSED_W-1:0] elapsed_inc;
    logic [ELAPSED_W-1:0] elapsed_half;
    logic [SUM_W-1:0]     avg_sum;
    logic [RAW_W-1:0]     tempo_raw;
    logic [RAW_W-1:0]     tempo_low;
    logic [TEMPO_W-1:0]   tempo_clamped;
    logic [TEMPO_W-1:0]   dist_hi;
    logic [TEMPO_W-1:0]   dist_lo;

    assign in_fire  = s_tvalid && s_tready;
    assign is_tap   = (s_tuser[0] == OP_TAP);
    assign half_ms  = s_tdata[0];
    assign out_free = !m_tvalid_reg || m_tready;
    assign probe    = pos_reg | step_reg;
    assign probe_ok = (probe <= N_POS);

    assign elapsed_inc  = (elapsed_reg != '1) ? elapsed_reg + 1'b1 : elapsed_reg;
    assign elapsed_half = half_ms ? elapsed_inc : elapsed_reg;

    assign avg_sum   = (SUM_W'(current_tempo_reg) << FRAC_W) + SUM_W'(product_reg)
                       + (SUM_W'(1) << FRAC_W);
    assign tempo_raw = second_tap_reg ? RAW_W'(product_reg >> FRAC_W)
                                      : RAW_W'(avg_sum >> (FRAC_W + 1));
    assign tempo_low = (tempo_raw < RAW_W'(MIN_TEMPO)) ? RAW_W'(MIN_TEMPO) : tempo_raw;
    assign tempo_clamped = (tempo_low > RAW_W'(delay_max_reg)) ? delay_max_reg
                                                               : tempo_low[TEMPO_W-1:0];

    assign dist_hi = rom_data_reg - tempo_reg;
    assign dist_lo = tempo_reg - lo_val_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && is_tap && (tap_count_reg != TAPS_NONE))
                begin
                    state_next = ST_MULT;
                end
            end
            ST_MULT:     state_next = ST_AVG;
            ST_AVG:      state_next = ST_SRCH_RD;
            ST_SRCH_RD:
            begin
                if (probe_ok)
                begin
                    state_next = ST_SRCH_CMP;
                end
                else if (step_reg[0])
                begin
                    state_next = ST_NEAR;
                end
            end
            ST_SRCH_CMP: state_next = step_reg[0] ? ST_NEAR : ST_SRCH_RD;
            ST_NEAR:
            begin
                if ((pos_reg == '0) || (pos_reg == N_POS))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_NEAR_LO;
                end
            end
            ST_NEAR_LO:  state_next = ST_NEAR_HI;
            ST_NEAR_HI:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready = 1'b0;
        rom_addr = '0;
        unique case (state_reg)
            ST_IDLE:     s_tready = 1'b1;
            ST_SRCH_RD:  rom_addr = ADDR_W'(probe - 1'b1);
            ST_NEAR:     rom_addr = ADDR_W'(pos_reg - 1'b1);
            ST_NEAR_LO:  rom_addr = ADDR_W'(pos_reg);
            default:     rom_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        rom_data_reg <= TEMPO_ROM[ROM_IDX_W'(rom_addr)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            delay_max_reg     <= DELAY_MAX_RST;
            tempo_scale_reg   <= TEMPO_SCALE_RST;
            timeout_reg       <= TIMEOUT_RST;
            tap_count_reg     <= TAPS_NONE;
            elapsed_reg       <= '0;
            current_tempo_reg <= '0;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_DELAY_MAX:   delay_max_reg   <= cfg_wdata[TEMPO_W-1:0];
                    CFG_TEMPO_SCALE: tempo_scale_reg <= cfg_wdata[SCALE_W-1:0];
                    CFG_TIMEOUT:     timeout_reg     <= cfg_wdata[ELAPSED_W-1:0];
                    default:         delay_max_reg   <= delay_max_reg;
                endcase
            end

            if (in_fire)
            begin
                if (!is_tap)
                begin
                    if (elapsed_inc > timeout_reg)
                    begin
                        elapsed_reg   <= '0;
                        tap_count_reg <= TAPS_NONE;
                    end
                    else
                    begin
                        elapsed_reg <= elapsed_inc;
                    end
                end
                else
                begin
                    elapsed_reg   <= '0;
                    tap_count_reg <= (tap_count_reg == TAPS_NONE) ? TAPS_ONE : TAPS_TWO;
                end
            end

            if (state_reg == ST_AVG)
            begin
                current_tempo_reg <= tempo_clamped;
            end

            if ((state_reg == ST_DONE) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                mul_a_reg      <= elapsed_half;
                second_tap_reg <= (tap_count_reg == TAPS_ONE);
            end
            ST_MULT:
            begin
                product_reg <= PROD_W'(mul_a_reg) * PROD_W'(tempo_scale_reg);
            end
            ST_AVG:
            begin
                tempo_reg <= tempo_clamped;
                pos_reg   <= '0;
                step_reg  <= STEP_INIT;
            end
            ST_SRCH_RD:
            begin
                if (!probe_ok)
                begin
                    step_reg <= step_reg >> 1;
                end
            end
            ST_SRCH_CMP:
            begin
                if (rom_data_reg < tempo_reg)
                begin
                    pos_reg <= probe;
                end
                step_reg <= step_reg >> 1;
            end
            ST_NEAR:
            begin
                if (pos_reg == '0)
                begin
                    wiper_pend_reg <= '0;
                end
                else
                begin
                    wiper_pend_reg <= WIPER_W'(N_POS - 1'b1);
                end
            end
            ST_NEAR_LO:
            begin
                lo_val_reg <= rom_data_reg;
            end
            ST_NEAR_HI:
            begin
                if (dist_hi <= dist_lo)
                begin
                    wiper_pend_reg <= WIPER_W'(pos_reg);
                end
                else
                begin
                    wiper_pend_reg <= WIPER_W'(pos_reg - 1'b1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_wiper_reg <= wiper_pend_reg;
                    m_tempo_reg <= tempo_reg;
                end
            end
            default:
            begin
                lo_val_reg <= lo_val_reg;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_W - WIPER_W - TEMPO_W){1'b0}}, m_tempo_reg, m_wiper_reg};

    a_tap_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        tap_count_reg != 2'd3)
        else $error("tap count beyond saturation");

    a_tick_timeout: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !is_tap && !cfg_wr_en) |=> (elapsed_reg <= timeout_reg))
        else $error("elapsed count above timeout after tick");

    a_search_pos: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SRCH_RD) || (state_reg == ST_SRCH_CMP)) |-> (pos_reg <= N_POS))
        else $error("search position beyond table");

    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result word without finished lookup");

    a_wiper_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (POS_W'(m_wiper_reg) < N_POS))
        else $error("wiper outside table");

endmodule

`default_nettype wire
